// File: design/lbsp_pkg.sv
// Shared types, constants and register codes of the LBSP window descriptor unit.
package lbsp_pkg;

  // Image geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int DIM_W = $clog2(MAX_WIDTH) + 1;   // width/height registers hold the maximum
  localparam int COL_W = $clog2(MAX_WIDTH);       // column index
  localparam int ROW_W = $clog2(MAX_HEIGHT);      // emitted row index
  localparam int POS_W = DIM_W + 1;               // row/column sums used for edge tests
  localparam int PIX_W = 24;                      // three 8-bit channels
  localparam int CH_W  = 8;

  // Window and line store shape
  localparam int WIN_N   = 5;
  localparam int LB_ROWS = WIN_N - 1;
  localparam int LB_W    = LB_ROWS * PIX_W;
  localparam int HALF    = WIN_N / 2;

  // Former-frame delay ring
  localparam int FORMER_DEPTH = 2 * MAX_WIDTH + 2;
  localparam int FPTR_W       = $clog2(FORMER_DEPTH);
  localparam int LIM_W        = $clog2(2 * MAX_WIDTH + 3);

  // Comparison widths
  localparam int DIFF_W = CH_W + 2;                // sum of three absolute differences
  localparam int PROD_W = DIFF_W + CH_W;           // ratio times channel sum

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Pattern points inside the 5x5 window
  localparam int PAT_N = 16;
  localparam int PAT_X [PAT_N] = '{0, 2, 4, 1, 2, 3, 0, 1, 3, 4, 1, 2, 3, 0, 2, 4};
  localparam int PAT_Y [PAT_N] = '{0, 0, 0, 1, 1, 1, 2, 2, 2, 2, 3, 3, 3, 4, 4, 4};

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH     = 3'd0,
    REG_IMAGE_HEIGHT    = 3'd1,
    REG_COLOR_MODE      = 3'd2,
    REG_INTER_MODE      = 3'd3,
    REG_INTRA_THRESHOLD = 3'd4,
    REG_INTER_RATIO     = 3'd5
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pixel_t;

  // Input beat
  typedef struct packed {
    logic            func;
    logic [CH_W-1:0] pix_c0;
    logic [CH_W-1:0] pix_c1;
    logic [CH_W-1:0] pix_c2;
    logic [CH_W-1:0] prev_c0;
    logic [CH_W-1:0] prev_c1;
    logic [CH_W-1:0] prev_c2;
  } pix_beat_t;

  // Output beat
  typedef struct packed {
    logic [PAT_N-1:0] descriptor;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic             frame_last;
  } desc_beat_t;

  // Effective configuration, dimensions already clamped
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             color_mode;
    logic             inter_mode;
    logic [CH_W-1:0]  intra_threshold;
    logic [CH_W-1:0]  inter_ratio;
  } cfg_t;

  // One classified window waiting for comparison
  typedef struct packed {
    pixel_t [PAT_N-1:0] nbr;
    pixel_t             centre;
    pixel_t             former;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               last;
  } window_entry_t;

endpackage

// File: design/lbsp_front.sv
// Front part: position tracking, line store, former-frame delay and window assembly.
module lbsp_front import lbsp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          pix_valid,
  output logic          pix_stall,
  input  pix_beat_t     pix_data,
  input  logic [QCNT_W-1:0] queue_count,
  output logic          push,
  output window_entry_t entry
);

  // First stage after acceptance
  typedef struct packed {
    pixel_t           pix;
    logic [COL_W-1:0] lb_col;
    logic             emit;
    logic             last;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic [WIN_N-1:0] row_ok;
    logic [WIN_N-1:0] col_ok;
  } stage_t;

  logic [COL_W-1:0]  in_column;
  logic [DIM_W-1:0]  in_row;
  logic [COL_W-1:0]  emit_column;
  logic [ROW_W-1:0]  emit_row;
  logic [LIM_W-1:0]  start_count;
  logic [FPTR_W-1:0] fwr_ptr;
  logic [FPTR_W-1:0] frd_ptr;
  logic [LIM_W-1:0]  lim;

  logic              accept;
  logic              pad;
  logic              col_wrap;
  logic              ecol_wrap;
  logic              emit;
  logic              last;
  pixel_t            pix_in;
  pixel_t            prv_in;
  logic [WIN_N-1:0]  row_ok;
  logic [WIN_N-1:0]  col_ok;

  logic              s1_valid;
  stage_t            s1;
  logic [LB_W-1:0]   lb_rd;
  logic [LB_W-1:0]   lb_wdata;
  pixel_t            former_rd;

  logic [LB_W-1:0]   line_mem [MAX_WIDTH];
  pixel_t            former_mem [FORMER_DEPTH];

  pixel_t            win [LB_ROWS][WIN_N];
  pixel_t            col_new [WIN_N];
  pixel_t            full [WIN_N][WIN_N];

  // Hold input while the queue cannot take every beat in flight
  assign pix_stall = ({1'b0, queue_count} + {{QCNT_W{1'b0}}, s1_valid})
                     >= (QCNT_W+1)'(QUEUE_DEPTH);
  assign accept    = pix_valid && !pix_stall;

  // Classify the beat
  assign lim       = LIM_W'({cfg.width, 1'b0}) + LIM_W'(2);
  assign pad       = pix_data.func || (in_row >= cfg.height);
  assign pix_in    = pad ? '0 : {pix_data.pix_c2, pix_data.pix_c1, pix_data.pix_c0};
  assign prv_in    = pad ? '0 : {pix_data.prev_c2, pix_data.prev_c1, pix_data.prev_c0};
  assign col_wrap  = (DIM_W'(in_column) + DIM_W'(1)) >= cfg.width;
  assign ecol_wrap = (DIM_W'(emit_column) + DIM_W'(1)) >= cfg.width;
  assign emit      = start_count >= lim;
  assign last      = emit && ((DIM_W'(emit_row) + DIM_W'(1)) >= cfg.height) && ecol_wrap;
  assign frd_ptr   = (LIM_W'(fwr_ptr) >= lim) ? FPTR_W'(LIM_W'(fwr_ptr) - lim)
                   : FPTR_W'(LIM_W'(fwr_ptr) + LIM_W'(FORMER_DEPTH) - lim);

  // Window rows and columns that fall inside the image
  always_comb begin
    for (int k = 0; k < WIN_N; k++) begin
      row_ok[k] = (POS_W'(emit_row) + POS_W'(k) >= POS_W'(HALF)) &&
                  (POS_W'(emit_row) + POS_W'(k) < POS_W'(cfg.height) + POS_W'(HALF));
      col_ok[k] = (POS_W'(emit_column) + POS_W'(k) >= POS_W'(HALF)) &&
                  (POS_W'(emit_column) + POS_W'(k) < POS_W'(cfg.width) + POS_W'(HALF));
    end
  end

  // Advance raster and emit positions
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column   <= '0;
      in_row      <= '0;
      emit_column <= '0;
      emit_row    <= '0;
      start_count <= '0;
      fwr_ptr     <= '0;
    end else if (accept) begin
      fwr_ptr <= (fwr_ptr == FPTR_W'(FORMER_DEPTH - 1)) ? '0 : fwr_ptr + 1'b1;
      if (last) begin
        in_column   <= '0;
        in_row      <= '0;
        emit_column <= '0;
        emit_row    <= '0;
        start_count <= '0;
      end else begin
        if (col_wrap) begin
          in_column <= '0;
          in_row    <= in_row + 1'b1;
        end else begin
          in_column <= in_column + 1'b1;
        end
        if (!emit) begin
          start_count <= start_count + 1'b1;
        end else if (ecol_wrap) begin
          emit_column <= '0;
          emit_row    <= emit_row + 1'b1;
        end else begin
          emit_column <= emit_column + 1'b1;
        end
      end
    end
  end

  // Stage one valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // Stage one payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1.pix    <= pix_in;
      s1.lb_col <= in_column;
      s1.emit   <= emit;
      s1.last   <= last;
      s1.col    <= emit_column;
      s1.row    <= emit_row;
      s1.row_ok <= row_ok;
      s1.col_ok <= col_ok;
    end
  end

  // Line store: four rows above the current pixel, one word per column
  assign lb_wdata = {s1.pix, lb_rd[LB_W-1:PIX_W]};

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_mem[s1.lb_col] <= lb_wdata;
    end
    if (accept) begin
      if (s1_valid && (s1.lb_col == in_column)) begin
        lb_rd <= lb_wdata;
      end else begin
        lb_rd <= line_mem[in_column];
      end
    end
  end

  // Former-frame delay ring, read before write
  always_ff @(posedge clk) begin
    if (accept) begin
      former_rd             <= former_mem[frd_ptr];
      former_mem[fwr_ptr]   <= prv_in;
    end
  end

  // Assemble the newest column and the full window
  always_comb begin
    for (int y = 0; y < LB_ROWS; y++) begin
      col_new[y] = lb_rd[y*PIX_W +: PIX_W];
    end
    col_new[LB_ROWS] = s1.pix;
    for (int x = 0; x < WIN_N; x++) begin
      for (int y = 0; y < WIN_N; y++) begin
        full[x][y] = (x == LB_ROWS) ? col_new[y] : win[x < LB_ROWS ? x : 0][y];
      end
    end
  end

  // Shift the window by one column
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      for (int x = 0; x < LB_ROWS - 1; x++) begin
        win[x] <= win[x+1];
      end
      win[LB_ROWS-1] <= col_new;
    end
  end

  // Build the queue entry, zero outside the image
  always_comb begin
    for (int i = 0; i < PAT_N; i++) begin
      entry.nbr[i] = (s1.row_ok[PAT_Y[i]] && s1.col_ok[PAT_X[i]]) ?
                     full[PAT_X[i]][PAT_Y[i]] : '0;
    end
    entry.centre = full[HALF][HALF];
    entry.former = former_rd;
    entry.col    = s1.col;
    entry.row    = s1.row;
    entry.last   = s1.last;
  end

  assign push = s1_valid && s1.emit;

  // After the frame's final beat the raster and emit counters restart
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && last) |=> (start_count == '0 && in_column == '0 && emit_row == '0))
    else $error("counters not cleared after frame end");

endmodule

// File: design/lbsp_queue.sv
// Short queue of classified windows between the front and back parts.
module lbsp_queue import lbsp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  window_entry_t     push_entry,
  input  logic              pop,
  output window_entry_t     head,
  output logic              not_empty,
  output logic [QCNT_W-1:0] count
);

  window_entry_t     slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && !pop && count == QCNT_W'(QUEUE_DEPTH)))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && count == '0))
    else $error("queue underflow");

endmodule

// File: design/lbsp_back.sv
// Back part: sixteen threshold compares and the output register.
module lbsp_back import lbsp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  window_entry_t head,
  input  logic          not_empty,
  output logic          pop,
  output logic          desc_valid,
  input  logic          desc_stall,
  output desc_beat_t    desc_data
);

  logic [PAT_N-1:0]  bits;
  logic [DIFF_W-1:0] fsum;
  logic [PROD_W-1:0] rel_limit;
  logic [DIFF_W-1:0] abs_limit;

  assign pop = not_empty && (!desc_valid || !desc_stall);

  // Thresholds shared by all pattern points
  always_comb begin
    fsum = cfg.color_mode ?
           (DIFF_W'(head.former[0 +: CH_W]) + DIFF_W'(head.former[CH_W +: CH_W]) +
            DIFF_W'(head.former[2*CH_W +: CH_W])) :
           DIFF_W'(head.former[0 +: CH_W]);
    rel_limit = PROD_W'(cfg.inter_ratio) * PROD_W'(fsum);
    abs_limit = cfg.color_mode ? DIFF_W'(cfg.intra_threshold) * DIFF_W'(3)
                               : DIFF_W'(cfg.intra_threshold);
  end

  // Compare every pattern point against the reference
  always_comb begin
    pixel_t            ref_pix;
    logic [CH_W-1:0]   a;
    logic [CH_W-1:0]   b;
    logic [DIFF_W-1:0] d;
    ref_pix = cfg.inter_mode ? head.former : head.centre;
    for (int i = 0; i < PAT_N; i++) begin
      d = '0;
      for (int k = 0; k < 3; k++) begin
        a = head.nbr[i][k*CH_W +: CH_W];
        b = ref_pix[k*CH_W +: CH_W];
        if (k == 0 || cfg.color_mode) begin
          d = d + DIFF_W'((a > b) ? a - b : b - a);
        end
      end
      bits[i] = cfg.inter_mode ? ({d, {CH_W{1'b0}}} > rel_limit) : (d > abs_limit);
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      desc_valid <= 1'b0;
    end else if (pop) begin
      desc_valid <= 1'b1;
    end else if (!desc_stall) begin
      desc_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      desc_data.descriptor <= bits;
      desc_data.out_col    <= head.col;
      desc_data.out_row    <= head.row;
      desc_data.frame_last <= head.last;
    end
  end

endmodule

// File: design/lbsp_window_descriptor_unit.sv
// Top level of the LBSP window descriptor unit: configuration registers and part wiring.
//
// Takes one raster pixel beat per clock when not stalled (gray or three channels plus the
// former frame's pixel) and returns one 16-bit 5x5 LBSP descriptor per frame pixel, in
// raster order. The descriptor of a pixel leaves once 2*W+2 further beats have come in,
// so each frame is followed by 2*W+2 flush beats (func set). Sustained rate is one beat
// per clock while desc_stall is low; the line store is one read and one write per beat,
// and the front pipeline is one stage deep plus a four-entry window queue and the output
// register, so a stalled output lets up to five beats in before pix_stall rises.
// Line and former-frame stores need no clearing after reset.
// Configuration writes belong between frames while no descriptor is pending.
module lbsp_window_descriptor_unit import lbsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_wdata,
  input  logic                 pix_valid,
  output logic                 pix_stall,
  input  pix_beat_t            pix_data,
  output logic                 desc_valid,
  input  logic                 desc_stall,
  output desc_beat_t           desc_data
);

  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic              color_mode;
  logic              inter_mode;
  logic [CH_W-1:0]   intra_threshold;
  logic [CH_W-1:0]   inter_ratio;
  cfg_t              cfg;

  logic              push;
  window_entry_t     entry;
  window_entry_t     head;
  logic              not_empty;
  logic              pop;
  logic [QCNT_W-1:0] queue_count;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= DIM_W'(640);
      image_height    <= DIM_W'(480);
      color_mode      <= 1'b0;
      inter_mode      <= 1'b0;
      intra_threshold <= CH_W'(25);
      inter_ratio     <= CH_W'(77);
    end else if (cfg_wen) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:     image_width     <= cfg_wdata;
        REG_IMAGE_HEIGHT:    image_height    <= cfg_wdata;
        REG_COLOR_MODE:      color_mode      <= cfg_wdata[0];
        REG_INTER_MODE:      inter_mode      <= cfg_wdata[0];
        REG_INTRA_THRESHOLD: intra_threshold <= cfg_wdata[CH_W-1:0];
        REG_INTER_RATIO:     inter_ratio     <= cfg_wdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry to the supported range
  always_comb begin
    cfg.width  = (image_width == '0) ? DIM_W'(1) :
                 (image_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : image_width;
    cfg.height = (image_height == '0) ? DIM_W'(1) :
                 (image_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : image_height;
    cfg.color_mode      = color_mode;
    cfg.inter_mode      = inter_mode;
    cfg.intra_threshold = intra_threshold;
    cfg.inter_ratio     = inter_ratio;
  end

  lbsp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .pix_valid   (pix_valid),
    .pix_stall   (pix_stall),
    .pix_data    (pix_data),
    .queue_count (queue_count),
    .push        (push),
    .entry       (entry)
  );

  lbsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .count      (queue_count)
  );

  lbsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .not_empty  (not_empty),
    .pop        (pop),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .desc_data  (desc_data)
  );

endmodule
